FILE: rtl/core/mmn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min-max normalizer package
// Shared types, request and status codes, and default sizes.
// ----------------------------------------------------------------------------
package mmn_pkg;

  localparam int MMN_MAX_SAMPLES  = 256;
  localparam int MMN_MAX_FEATURES = 16;
  localparam int Q_FRAC           = 16;

  localparam logic [4:0] FC_RESET = 5'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_QUOT
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD_UPD,
    S_RD_CALC,
    S_RD_CHECK,
    S_DIV,
    S_ROUND,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       st_wr;
    logic       mm_wr;
    logic       clear;
    logic       nd_load;
    logic       div_start;
    logic       div_step;
    logic       res_wr;
    res_sel_t   res_sel;
    logic [1:0] res_status;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic oob;
    logic flat;
    logic sat;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/mmn_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min-max normalizer divider
// Radix-2 restoring divider for a fraction num/den with num < den, one
// quotient bit per step, rounded to nearest with ties up.
// ----------------------------------------------------------------------------
module mmn_div
  import mmn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              step,
  input  wire logic [31:0]       num,
  input  wire logic [31:0]       den,
  output logic                   last,
  output logic [Q_FRAC:0]        quot
);

  localparam int CNTW = (Q_FRAC > 1) ? $clog2(Q_FRAC) : 1;
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(Q_FRAC - 1);

  logic [CNTW-1:0]   cnt;
  logic [31:0]       rem;
  logic [31:0]       dreg;
  logic [Q_FRAC-1:0] q;
  logic [32:0]       shifted;
  logic [32:0]       diff;
  logic              take;
  logic              rnd;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dreg};
  assign take    = shifted >= {1'b0, dreg};
  assign last    = (cnt == CNT_LAST);
  assign rnd     = ({1'b0, rem} + {2'b00, dreg[31:1]}) >= {1'b0, dreg};
  assign quot    = {1'b0, q} + (Q_FRAC + 1)'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dreg <= den;
      q    <= '0;
    end else if (step) begin
      rem <= take ? diff[31:0] : shifted[31:0];
      q   <= {q[Q_FRAC-2:0], take};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mmn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min-max normalizer controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
module mmn_ctrl
  import mmn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_sel    = RES_ZERO;
    cmd.res_status = ST_OK;
    in_stall       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req)
          REQ_LOAD: begin
            if (stat.full) begin
              cmd.res_wr     = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_OUT;
            end else begin
              cmd.st_wr  = 1'b1;
              state_next = S_LOAD_UPD;
            end
          end
          REQ_READ: begin
            if (stat.empty) begin
              cmd.res_wr     = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_OUT;
            end else if (stat.oob) begin
              cmd.res_wr     = 1'b1;
              cmd.res_status = ST_RANGE;
              state_next     = S_OUT;
            end else begin
              state_next = S_RD_CALC;
            end
          end
          REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.res_wr = 1'b1;
            state_next = S_OUT;
          end
          default: begin
            cmd.res_wr = 1'b1;
            state_next = S_OUT;
          end
        endcase
      end
      S_LOAD_UPD: begin
        cmd.mm_wr  = 1'b1;
        cmd.res_wr = 1'b1;
        state_next = S_OUT;
      end
      S_RD_CALC: begin
        cmd.nd_load = 1'b1;
        state_next  = S_RD_CHECK;
      end
      S_RD_CHECK: begin
        if (stat.flat) begin
          cmd.res_wr = 1'b1;
          state_next = S_OUT;
        end else if (stat.sat) begin
          cmd.res_wr  = 1'b1;
          cmd.res_sel = RES_ONE;
          state_next  = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.res_wr  = 1'b1;
        cmd.res_sel = RES_QUOT;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/mmn_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min-max normalizer datapath
// Sample store, per-feature min/max memory, load counters, divider and the
// output register.
// ----------------------------------------------------------------------------
module mmn_datapath
  import mmn_pkg::*;
#(
  parameter int MAX_SAMPLES  = MMN_MAX_SAMPLES,
  parameter int MAX_FEATURES = MMN_MAX_FEATURES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [4:0]         cfg_wdata,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] value,
  input  wire logic [7:0]         sample_index,
  input  wire logic [3:0]         feature_index,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [16:0]             normalized,
  output logic [1:0]              status,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat
);

  localparam int PW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int TW    = $clog2(MAX_SAMPLES + 1);
  localparam int DEPTH = MAX_SAMPLES * MAX_FEATURES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = ($clog2(MAX_FEATURES + 1) > 5) ? $clog2(MAX_FEATURES + 1) : 5;
  localparam int SW    = (TW > 8) ? TW : 8;

  logic [4:0]         feature_count;
  logic [CW-1:0]      fc_raw;
  logic [CW-1:0]      fc_eff;

  req_t               req_r;
  logic signed [31:0] value_r;
  logic [7:0]         sidx_r;
  logic [3:0]         fidx_r;
  logic [PW-1:0]      fidx_p;

  logic [PW-1:0]      pos;
  logic [TW-1:0]      total;

  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        store_mem [DEPTH];
  logic [31:0]        st_rdata;

  logic [PW-1:0]      mm_raddr;
  logic [63:0]        mm_mem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] mm_valid;
  logic [63:0]        mm_rdata;
  logic               mm_rvld;
  logic signed [31:0] mm_min;
  logic signed [31:0] mm_max;
  logic signed [31:0] new_min;
  logic signed [31:0] new_max;

  logic signed [32:0] num_r;
  logic signed [32:0] den_r;
  logic [Q_FRAC:0]    quot;
  logic               div_last;

  logic [16:0]        res_norm;
  logic [1:0]         res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count <= FC_RESET;
    end else if (cfg_wen) begin
      feature_count <= cfg_wdata;
    end
  end

  always_comb begin
    fc_raw = CW'(feature_count);
    if (fc_raw == '0) begin
      fc_eff = CW'(1);
    end else if (fc_raw > CW'(MAX_FEATURES)) begin
      fc_eff = CW'(MAX_FEATURES);
    end else begin
      fc_eff = fc_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= req_t'(req_type);
      value_r <= value;
      sidx_r  <= sample_index;
      fidx_r  <= feature_index;
    end
  end

  assign fidx_p   = PW'(fidx_r);
  assign wr_addr  = AW'(total) * AW'(MAX_FEATURES) + AW'(pos);
  assign rd_addr  = AW'(sidx_r) * AW'(MAX_FEATURES) + AW'(fidx_p);
  assign mm_raddr = (req_r == REQ_LOAD) ? pos : fidx_p;

  always_ff @(posedge clk) begin
    if (cmd.st_wr) begin
      store_mem[wr_addr] <= value_r;
    end
    st_rdata <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mm_wr) begin
      mm_mem[pos] <= {new_max, new_min};
    end
    mm_rdata <= mm_mem[mm_raddr];
    mm_rvld  <= mm_valid[mm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mm_valid <= '0;
    end else if (cmd.mm_wr) begin
      mm_valid[pos] <= 1'b1;
    end
  end

  assign mm_min  = mm_rvld ? mm_rdata[31:0]  : 32'sh7FFF_FFFF;
  assign mm_max  = mm_rvld ? mm_rdata[63:32] : 32'sh8000_0000;
  assign new_min = (value_r < mm_min) ? value_r : mm_min;
  assign new_max = (value_r > mm_max) ? value_r : mm_max;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pos   <= '0;
      total <= '0;
    end else if (cmd.mm_wr) begin
      if (CW'(pos) + CW'(1) >= fc_eff) begin
        pos   <= '0;
        total <= total + TW'(1);
      end else begin
        pos <= pos + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nd_load) begin
      num_r <= {st_rdata[31], st_rdata} - {mm_min[31], mm_min};
      den_r <= {mm_max[31], mm_max} - {mm_min[31], mm_min};
    end
  end

  mmn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .step  (cmd.div_step),
    .num   (num_r[31:0]),
    .den   (den_r[31:0]),
    .last  (div_last),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        RES_ONE:  res_norm <= 17'(1 << Q_FRAC);
        RES_QUOT: res_norm <= 17'(quot);
        default:  res_norm <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      normalized <= res_norm;
      status     <= res_status;
    end
  end

  always_comb begin
    stat.req      = req_r;
    stat.full     = (total == TW'(MAX_SAMPLES));
    stat.empty    = (total == '0);
    stat.oob      = (SW'(sidx_r) >= SW'(total)) || (CW'(fidx_r) >= fc_eff);
    stat.flat     = (den_r <= 33'sd0) || (num_r <= 33'sd0);
    stat.sat      = (num_r >= den_r);
    stat.div_last = div_last;
    stat.out_busy = out_valid && out_stall;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(MAX_SAMPLES))
    else $error("sample count exceeds store depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(pos) < CW'(MAX_FEATURES))
    else $error("load position beyond feature range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output beat overwritten while stalled");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (total == '0 && pos == '0 && mm_valid == '0))
    else $error("clear did not empty the set");

endmodule
`default_nettype wire

FILE: rtl/core/min_max_feature_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min-max feature normalizer
// Loads feature values sample by sample, tracks per-feature min and max, and
// returns (value - min) / (max - min) as an unsigned Q1.16 fraction.
//
// The input channel (in_valid/in_stall) carries one request per beat: load,
// read or clear. The output channel (out_valid/out_stall) returns exactly one
// beat per request with normalized and status. The feature count register is
// written through cfg_wen/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. Requests are
// handled one at a time. A load writes the store and the min/max memory; a
// read that passes its checks runs the radix-2 divider, one quotient bit per
// cycle, unless the feature is flat or saturated. The result sits in an
// output register, so the next request is accepted while the previous result
// waits; if the receiver holds out_stall, the next result waits in the result
// register until the output register is taken. Synchronous reset empties the
// set, clears the min/max state and sets the feature count to 2. The sample
// store needs no clearing pass.
// ----------------------------------------------------------------------------
module min_max_feature_normalizer
  import mmn_pkg::*;
#(
  parameter int MAX_SAMPLES  = MMN_MAX_SAMPLES,
  parameter int MAX_FEATURES = MMN_MAX_FEATURES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [4:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] value,
  input  wire logic [7:0]         sample_index,
  input  wire logic [3:0]         feature_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             normalized,
  output logic [1:0]              status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmn_datapath #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .req_type      (req_type),
    .value         (value),
    .sample_index  (sample_index),
    .feature_index (feature_index),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .normalized    (normalized),
    .status        (status),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
`default_nettype wire

FILE: tb/mmn_norm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max normalizer checker
// Watches the configuration port and both channels of the normalizer. Every
// accepted request beat is applied to a local copy of the sample store and the
// per-feature minimum and maximum, and the normalized value and status it
// should produce are queued. Each accepted result beat is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module mmn_norm_checker
  import mmn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] value,
  input  logic [7:0]         sample_index,
  input  logic [3:0]         feature_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [16:0]        normalized,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [16:0] norm;
    logic [1:0]  stat;
  } norm_result_t;

  logic [4:0]         feat_cfg;
  logic signed [31:0] stored [MMN_MAX_SAMPLES * MMN_MAX_FEATURES];
  logic signed [31:0] run_min [MMN_MAX_FEATURES];
  logic signed [31:0] run_max [MMN_MAX_FEATURES];
  int unsigned        load_pos;
  int unsigned        full_samples;
  norm_result_t       due_results[$];

  function automatic int unsigned active_features();
    if (feat_cfg == 0) return 1;
    if (feat_cfg > MMN_MAX_FEATURES) return MMN_MAX_FEATURES;
    return 32'(feat_cfg);
  endfunction

  function automatic logic [16:0] scale_entry(input logic signed [31:0] v,
                                              input logic signed [31:0] lo,
                                              input logic signed [31:0] hi);
    longint num;
    longint den;
    num = longint'(v) - longint'(lo);
    den = longint'(hi) - longint'(lo);
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return 17'(longint'(1) << Q_FRAC);
    return 17'(((num << Q_FRAC) + den / 2) / den);
  endfunction

  task automatic clear_dataset();
    foreach (stored[i]) stored[i] = '0;
    foreach (run_min[i]) begin
      run_min[i] = 32'sh7FFF_FFFF;
      run_max[i] = 32'sh8000_0000;
    end
    load_pos     = 0;
    full_samples = 0;
  endtask

  task automatic apply_request(input req_t req, input logic signed [31:0] v,
                               input logic [7:0] s, input logic [3:0] f,
                               output norm_result_t res);
    res = '{norm: '0, stat: ST_OK};
    case (req)
      REQ_LOAD: begin
        if (full_samples >= MMN_MAX_SAMPLES) begin
          res.stat = ST_FULL;
        end else begin
          stored[full_samples * MMN_MAX_FEATURES + load_pos] = v;
          if (v < run_min[load_pos]) run_min[load_pos] = v;
          if (v > run_max[load_pos]) run_max[load_pos] = v;
          if (load_pos + 1 >= active_features()) begin
            load_pos = 0;
            full_samples++;
          end else begin
            load_pos++;
          end
        end
      end
      REQ_READ: begin
        if (full_samples == 0) begin
          res.stat = ST_EMPTY;
        end else if (s >= full_samples || f >= active_features()) begin
          res.stat = ST_RANGE;
        end else begin
          res.norm = scale_entry(stored[s * MMN_MAX_FEATURES + f], run_min[f], run_max[f]);
        end
      end
      REQ_CLEAR: clear_dataset();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    norm_result_t want;
    if (rst) begin
      feat_cfg   = FC_RESET;
      fail_count = 0;
      clear_dataset();
      due_results.delete();
    end else begin
      if (cfg_wen) feat_cfg = cfg_wdata;
      if (in_valid && !in_stall) begin
        apply_request(req_t'(req_type), value, sample_index, feature_index, want);
        due_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("Result beat with nothing expected: normalized %0d status %0d",
                 normalized, status);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (normalized !== want.norm) begin
            $error("normalized mismatch: expected %0d, actual %0d", want.norm, normalized);
            fail_count++;
          end
          if (status !== want.stat) begin
            $error("status mismatch: expected %0d, actual %0d", want.stat, status);
            fail_count++;
          end
        end
      end
    end
    pending = due_results.size();
  end

endmodule

FILE: tb/tb_min_max_feature_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max feature normalizer testbench
// Drives load, read, clear and unused requests into the normalizer under
// several feature counts, with random gaps on the request side and random
// stalls on the result side. A directed opening covers the value extremes,
// empty and out-of-range reads and flat features; random phases follow,
// including a count change in the middle of a sample and a run that fills
// the store. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_min_max_feature_normalizer;
  import mmn_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [4:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic [1:0]         req_type = REQ_NONE;
  logic signed [31:0] value = '0;
  logic [7:0]         sample_index = '0;
  logic [3:0]         feature_index = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [16:0]        normalized;
  logic [1:0]         status;
  int                 fail_count;
  int                 pending;

  bit                 calm = 1'b0;
  logic [4:0]         cfg_mirror = FC_RESET;
  int                 sample_cnt = 0;
  int                 next_pos = 0;
  int                 sample_len [MMN_MAX_SAMPLES];
  int                 val_shift = 0;

  min_max_feature_normalizer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .value        (value),
    .sample_index (sample_index),
    .feature_index(feature_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .normalized   (normalized),
    .status       (status)
  );

  mmn_norm_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .value        (value),
    .sample_index (sample_index),
    .feature_index(feature_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .normalized   (normalized),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(0, 99) < 18);
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int eff_features();
    if (cfg_mirror == 0) return 1;
    if (cfg_mirror > MMN_MAX_FEATURES) return MMN_MAX_FEATURES;
    return int'(cfg_mirror);
  endfunction

  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      default: return raw >>> val_shift;
    endcase
  endfunction

  // Keeps the written prefix length of each sample so that reads never touch
  // an entry that was never loaded.
  task automatic track(input req_t r);
    case (r)
      REQ_LOAD: begin
        if (sample_cnt < MMN_MAX_SAMPLES) begin
          if (next_pos + 1 > sample_len[sample_cnt]) sample_len[sample_cnt] = next_pos + 1;
          if (next_pos + 1 >= eff_features()) begin
            next_pos = 0;
            sample_cnt++;
          end else begin
            next_pos++;
          end
        end
      end
      REQ_CLEAR: begin
        sample_cnt = 0;
        next_pos   = 0;
        foreach (sample_len[i]) sample_len[i] = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send(input req_t r, input logic signed [31:0] v,
                      input logic [7:0] s, input logic [3:0] f);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    req_type      = r;
    value         = v;
    sample_index  = s;
    feature_index = f;
    do @(posedge clk); while (in_stall);
    track(r);
  endtask

  task automatic send_load(input logic signed [31:0] v);
    send(REQ_LOAD, v, 8'($urandom), 4'($urandom));
  endtask

  task automatic send_read();
    logic [7:0] s;
    logic [3:0] f;
    if (sample_cnt > 0 && $urandom_range(0, 9) < 8) begin
      s = 8'($urandom_range(0, sample_cnt - 1));
      f = 4'($urandom_range(0, sample_len[s] - 1));
    end else begin
      s = 8'($urandom);
      f = 4'($urandom);
      if (s < sample_cnt && f < eff_features() && f >= sample_len[s]) f = 4'(sample_len[s] - 1);
    end
    send(REQ_READ, $urandom, s, f);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_features(input logic [4:0] fc);
    drain();
    repeat (4) @(negedge clk);
    cfg_wen    = 1'b1;
    cfg_wdata  = fc;
    cfg_mirror = fc;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic run_mix(input int n, input bit pause_mid);
    int pick;
    val_shift = $urandom_range(0, 24);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        send_load(rand_value());
      end else if (pick < 96) begin
        send_read();
      end else if (pick < 98) begin
        send(REQ_NONE, $urandom, 8'($urandom), 4'($urandom));
      end else begin
        send(REQ_CLEAR, $urandom, 8'($urandom), 4'($urandom));
      end
    end
  endtask

  initial begin
    foreach (sample_len[i]) sample_len[i] = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send(REQ_READ, '0, 8'd0, 4'd0);
    send(REQ_NONE, 32'hFFFF_FFFF, 8'hFF, 4'hF);
    send(REQ_CLEAR, '0, '0, '0);
    send_load(32'sh7FFF_FFFF);
    send_load(32'sh8000_0000);
    send_load(32'sh0000_0000);
    send_load(32'shFFFF_FFFF);
    send(REQ_READ, '0, 8'd0, 4'd0);
    send(REQ_READ, '0, 8'd1, 4'd0);
    send(REQ_READ, '0, 8'd0, 4'd1);
    send(REQ_READ, '0, 8'd1, 4'd1);
    send(REQ_READ, '0, 8'd2, 4'd0);
    send(REQ_READ, '0, 8'd255, 4'd15);
    send(REQ_READ, '0, 8'd1, 4'd2);
    send_load(32'sh0001_0000);
    send_load(32'sh0000_8000);
    send(REQ_READ, '0, 8'd2, 4'd0);
    send(REQ_READ, '0, 8'd2, 4'd1);
    send(REQ_CLEAR, 32'hFFFF_FFFF, 8'hFF, 4'hF);
    send(REQ_READ, '0, 8'd0, 4'd0);
    send_load(32'sh0000_1234);
    send_load(32'sh0000_1234);
    send(REQ_READ, '0, 8'd0, 4'd0);
    send(REQ_READ, '0, 8'd0, 4'd1);

    set_features(5'd16);
    calm = 1'b1;
    run_mix(40, 1'b1);
    calm = 1'b0;
    while (next_pos < 8) send_load(rand_value());
    set_features(5'd3);
    run_mix(30, 1'b0);
    set_features(5'd31);
    run_mix(30, 1'b1);
    set_features(5'd0);
    send(REQ_CLEAR, '0, '0, '0);
    run_mix(30, 1'b0);

    set_features(5'd1);
    send(REQ_CLEAR, '0, '0, '0);
    val_shift = $urandom_range(0, 12);
    while (sample_cnt < MMN_MAX_SAMPLES) begin
      if ($urandom_range(0, 9) == 0) begin
        send_read();
      end else begin
        send_load(rand_value());
      end
    end
    repeat (4) send_load(rand_value());
    repeat (20) send_read();

    set_features(5'd5);
    run_mix(30, 1'b0);
    set_features(5'd2);
    run_mix(20, 1'b0);

    drain();
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
